// ===== src/mcbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbd_pkg
// Shared types and constants for the multi-click button detector.
// ----------------------------------------------------------------------------
package mcbd_pkg;

    localparam int DebounceW = 8;
    localparam int LongW     = 16;
    localparam int SettleW   = 16;
    localparam int ClicksW   = 4;
    localparam int TimerW    = 17;
    localparam int CountW    = 4;
    localparam int KindW     = 2;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 16;
    localparam int StateW    = 2;

    localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_LONG     = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_SETTLE   = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_MAXCLK   = 2'd3;

    localparam logic [DebounceW-1:0] DEBOUNCE_RST = 8'd20;
    localparam logic [LongW-1:0]     LONG_RST     = 16'd2000;
    localparam logic [SettleW-1:0]   SETTLE_RST   = 16'd500;
    localparam logic [ClicksW-1:0]   MAXCLK_RST   = 4'd6;

    localparam logic [StateW-1:0] ST_UP   = 2'd0;
    localparam logic [StateW-1:0] ST_DOWN = 2'd1;
    localparam logic [StateW-1:0] ST_LONG = 2'd2;
    localparam logic [StateW-1:0] ST_IDLE = 2'd3;

    localparam logic [KindW-1:0] EV_NONE  = 2'd0;
    localparam logic [KindW-1:0] EV_CLICK = 2'd1;
    localparam logic [KindW-1:0] EV_LONG  = 2'd2;
    localparam logic [KindW-1:0] EV_MANY  = 2'd3;

    typedef struct packed {
        logic [DebounceW-1:0] debounce_ticks;
        logic [LongW-1:0]     long_press_ticks;
        logic [SettleW-1:0]   settle_ticks;
        logic [ClicksW-1:0]   max_clicks;
    } cfg_t;

    typedef struct packed {
        logic [KindW-1:0]  event_kind;
        logic [CountW-1:0] click_count;
        logic              is_down;
    } result_t;

endpackage

// ===== src/multi_click_button_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_click_button_detector
// Debounced button tick processor giving click-run, long-press and
// too-many-click events, one result per sample tick.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------
//  in      | in_valid / in_stall | level_low
//  out     | out_valid/out_stall | event_kind, click_count, is_down
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One tick per cycle while in_stall is low; its result is registered.
//  The state update and compares sit between the state registers and the
//  result register; a skid entry holds one result while the output stalls.
//  in_stall rises only when the skid entry is occupied.
//  Reset: idle, button released, timers zero, registers at default values.
// ----------------------------------------------------------------------------
module multi_click_button_detector (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          level_low,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mcbd_pkg::KindW-1:0]    event_kind,
    output logic [mcbd_pkg::CountW-1:0]   click_count,
    output logic                          is_down,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mcbd_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [mcbd_pkg::CfgDataW-1:0] cfg_data
);

    mcbd_pkg::cfg_t    cfg;
    mcbd_pkg::result_t step_result;
    mcbd_pkg::result_t out_data;
    logic              full;
    logic              step;

    assign in_stall    = full;
    assign step        = in_valid && !full;
    assign event_kind  = out_data.event_kind;
    assign click_count = out_data.click_count;
    assign is_down     = out_data.is_down;

    mcbd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mcbd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .level_low (level_low),
        .cfg       (cfg),
        .result    (step_result)
    );

    mcbd_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_data (step_result),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== src/mcbd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbd_cfg_regs
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module mcbd_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mcbd_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [mcbd_pkg::CfgDataW-1:0] cfg_data,
    output mcbd_pkg::cfg_t                cfg
);

    mcbd_pkg::cfg_t cfg_reg;
    mcbd_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                mcbd_pkg::CFG_DEBOUNCE:
                    cfg_next.debounce_ticks = cfg_data[mcbd_pkg::DebounceW-1:0];
                mcbd_pkg::CFG_LONG:
                    cfg_next.long_press_ticks = cfg_data[mcbd_pkg::LongW-1:0];
                mcbd_pkg::CFG_SETTLE:
                    cfg_next.settle_ticks = cfg_data[mcbd_pkg::SettleW-1:0];
                mcbd_pkg::CFG_MAXCLK:
                    cfg_next.max_clicks = cfg_data[mcbd_pkg::ClicksW-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= mcbd_pkg::DEBOUNCE_RST;
            cfg_reg.long_press_ticks <= mcbd_pkg::LONG_RST;
            cfg_reg.settle_ticks     <= mcbd_pkg::SETTLE_RST;
            cfg_reg.max_clicks       <= mcbd_pkg::MAXCLK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/mcbd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbd_core
// Debounce, phase timing and press state machine; one tick per transfer.
// ----------------------------------------------------------------------------
module mcbd_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                level_low,
    input  mcbd_pkg::cfg_t      cfg,
    output mcbd_pkg::result_t   result
);

    localparam logic [mcbd_pkg::DebounceW-1:0] SINCE_MAX = '1;
    localparam logic [mcbd_pkg::TimerW-1:0]    TIMER_MAX = '1;
    localparam logic [mcbd_pkg::CountW-1:0]    COUNT_MAX = '1;

    logic [mcbd_pkg::StateW-1:0]    state_reg, state_next;
    logic                           last_level_reg, last_level_next;
    logic [mcbd_pkg::DebounceW-1:0] since_reg, since_next, since_inc;
    logic [mcbd_pkg::TimerW-1:0]    timer_reg, timer_next, timer_inc;
    logic [mcbd_pkg::CountW-1:0]    count_reg, count_next, count_base;
    logic [mcbd_pkg::KindW-1:0]     kind;
    logic [mcbd_pkg::CountW-1:0]    click_count;

    always_comb
    begin
        since_inc  = (since_reg == SINCE_MAX) ? since_reg : since_reg + 1'b1;
        timer_inc  = (timer_reg == TIMER_MAX) ? timer_reg : timer_reg + 1'b1;
        count_base = (state_reg == mcbd_pkg::ST_IDLE) ? '0 : count_reg;

        state_next      = state_reg;
        last_level_next = last_level_reg;
        since_next      = since_inc;
        timer_next      = timer_inc;
        count_next      = count_reg;
        kind            = mcbd_pkg::EV_NONE;
        click_count     = '0;

        if (since_inc >= cfg.debounce_ticks)
        begin
            if (level_low != last_level_reg)
            begin
                last_level_next = level_low;
                since_next      = '0;
            end
            if (level_low)
            begin
                unique case (state_reg) inside
                    mcbd_pkg::ST_IDLE, mcbd_pkg::ST_UP:
                    begin
                        count_next = (count_base == COUNT_MAX) ? count_base
                                                               : count_base + 1'b1;
                        state_next = mcbd_pkg::ST_DOWN;
                        timer_next = '0;
                    end
                    mcbd_pkg::ST_DOWN:
                    begin
                        if (timer_inc > {1'b0, cfg.long_press_ticks})
                            state_next = mcbd_pkg::ST_LONG;
                    end
                    default:
                        state_next = state_reg;
                endcase
            end
            else
            begin
                unique case (state_reg)
                    mcbd_pkg::ST_DOWN:
                    begin
                        state_next = mcbd_pkg::ST_UP;
                        timer_next = '0;
                    end
                    mcbd_pkg::ST_UP:
                    begin
                        if (timer_inc > {1'b0, cfg.settle_ticks})
                        begin
                            click_count = count_reg;
                            kind        = (count_reg > cfg.max_clicks) ? mcbd_pkg::EV_MANY
                                                                       : mcbd_pkg::EV_CLICK;
                            state_next  = mcbd_pkg::ST_IDLE;
                        end
                    end
                    mcbd_pkg::ST_LONG:
                    begin
                        kind       = mcbd_pkg::EV_LONG;
                        state_next = mcbd_pkg::ST_IDLE;
                    end
                    default:
                        state_next = state_reg;
                endcase
            end
        end

        result.event_kind  = kind;
        result.click_count = click_count;
        result.is_down     = (state_next == mcbd_pkg::ST_DOWN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mcbd_pkg::ST_IDLE;
            last_level_reg <= 1'b0;
            since_reg      <= '0;
            timer_reg      <= '0;
            count_reg      <= '0;
        end
        else if (step)
        begin
            state_reg      <= state_next;
            last_level_reg <= last_level_next;
            since_reg      <= since_next;
            timer_reg      <= timer_next;
            count_reg      <= count_next;
        end
    end

endmodule

// ===== src/mcbd_out_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbd_out_skid
// Result register with a skid entry; stall toward the input is registered.
// ----------------------------------------------------------------------------
module mcbd_out_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mcbd_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output mcbd_pkg::result_t out_data
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    mcbd_pkg::result_t out_data_reg, out_data_next;
    mcbd_pkg::result_t skid_data_reg, skid_data_next;
    logic              pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_next = push;
            out_data_next  = push_data;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== verif/button_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_event_checker
// Watches the tick, event and register channels of the button detector,
// predicts one event record per accepted tick from its own model of the
// debounce, press-run and long-press logic, and compares each event record
// that leaves the block against the oldest prediction.
// ----------------------------------------------------------------------------
module button_event_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          level_low,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [mcbd_pkg::KindW-1:0]    event_kind,
    input  logic [mcbd_pkg::CountW-1:0]   click_count,
    input  logic                          is_down,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [mcbd_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [mcbd_pkg::CfgDataW-1:0] cfg_data,
    output int                            mismatches,
    output int                            outstanding,
    output int                            ticks_seen,
    output int                            clicks_seen,
    output int                            many_seen,
    output int                            longs_seen,
    output int                            writes_seen
);

    mcbd_pkg::cfg_t                 settings;
    logic [mcbd_pkg::StateW-1:0]    btn_state;
    logic                           seen_level;
    logic [mcbd_pkg::DebounceW-1:0] ticks_since_edge;
    logic [mcbd_pkg::TimerW-1:0]    phase_ticks;
    logic [mcbd_pkg::CountW-1:0]    run_presses;
    mcbd_pkg::result_t              expected_events[$];

    int n_bad   = 0;
    int n_ticks = 0;
    int n_click = 0;
    int n_many  = 0;
    int n_long  = 0;
    int n_write = 0;
    int n_queue = 0;

    assign mismatches  = n_bad;
    assign outstanding = n_queue;
    assign ticks_seen  = n_ticks;
    assign clicks_seen = n_click;
    assign many_seen   = n_many;
    assign longs_seen  = n_long;
    assign writes_seen = n_write;

    task automatic report_mismatch(input string msg);
        if (n_bad < 40)
            $display("[%0t] mismatch: %s", $time, msg);
        n_bad++;
    endtask

    task automatic predict_tick(input logic lvl, output mcbd_pkg::result_t rec);
        logic [mcbd_pkg::KindW-1:0]  kind;
        logic [mcbd_pkg::CountW-1:0] cnt;
        kind = mcbd_pkg::EV_NONE;
        cnt  = '0;
        if (ticks_since_edge != {mcbd_pkg::DebounceW{1'b1}})
            ticks_since_edge++;
        if (phase_ticks != {mcbd_pkg::TimerW{1'b1}})
            phase_ticks++;
        if (ticks_since_edge >= settings.debounce_ticks)
        begin
            if (lvl != seen_level)
            begin
                seen_level       = lvl;
                ticks_since_edge = '0;
            end
            if (lvl)
            begin
                if (btn_state == mcbd_pkg::ST_IDLE || btn_state == mcbd_pkg::ST_UP)
                begin
                    if (btn_state == mcbd_pkg::ST_IDLE)
                        run_presses = '0;
                    if (run_presses != {mcbd_pkg::CountW{1'b1}})
                        run_presses++;
                    btn_state   = mcbd_pkg::ST_DOWN;
                    phase_ticks = '0;
                end
                else if (btn_state == mcbd_pkg::ST_DOWN &&
                         phase_ticks > settings.long_press_ticks)
                    btn_state = mcbd_pkg::ST_LONG;
            end
            else
            begin
                case (btn_state)
                    mcbd_pkg::ST_DOWN:
                    begin
                        btn_state   = mcbd_pkg::ST_UP;
                        phase_ticks = '0;
                    end
                    mcbd_pkg::ST_UP:
                    begin
                        if (phase_ticks > settings.settle_ticks)
                        begin
                            cnt       = run_presses;
                            kind      = (run_presses > settings.max_clicks) ?
                                        mcbd_pkg::EV_MANY : mcbd_pkg::EV_CLICK;
                            btn_state = mcbd_pkg::ST_IDLE;
                        end
                    end
                    mcbd_pkg::ST_LONG:
                    begin
                        kind      = mcbd_pkg::EV_LONG;
                        btn_state = mcbd_pkg::ST_IDLE;
                    end
                    default: ;
                endcase
            end
        end
        rec.event_kind  = kind;
        rec.click_count = cnt;
        rec.is_down     = (btn_state == mcbd_pkg::ST_DOWN);
    endtask

    task automatic check_event();
        mcbd_pkg::result_t want;
        if (expected_events.size() == 0)
        begin
            report_mismatch($sformatf("event kind %0d with no tick outstanding", event_kind));
            return;
        end
        want = expected_events.pop_front();
        if (event_kind !== want.event_kind)
            report_mismatch($sformatf("event_kind got %0d want %0d",
                                      event_kind, want.event_kind));
        if (click_count !== want.click_count)
            report_mismatch($sformatf("click_count got %0d want %0d",
                                      click_count, want.click_count));
        if (is_down !== want.is_down)
            report_mismatch($sformatf("is_down got %0d want %0d", is_down, want.is_down));
        case (want.event_kind)
            mcbd_pkg::EV_CLICK: n_click++;
            mcbd_pkg::EV_MANY:  n_many++;
            mcbd_pkg::EV_LONG:  n_long++;
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mcbd_pkg::result_t rec;
        if (!rst_n)
        begin
            settings.debounce_ticks   = mcbd_pkg::DEBOUNCE_RST;
            settings.long_press_ticks = mcbd_pkg::LONG_RST;
            settings.settle_ticks     = mcbd_pkg::SETTLE_RST;
            settings.max_clicks       = mcbd_pkg::MAXCLK_RST;
            btn_state        = mcbd_pkg::ST_IDLE;
            seen_level       = 1'b0;
            ticks_since_edge = '0;
            phase_ticks      = '0;
            run_presses      = '0;
            expected_events.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
                check_event();
            if (in_valid && !in_stall)
            begin
                predict_tick(level_low, rec);
                expected_events.push_back(rec);
                n_ticks++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mcbd_pkg::CFG_DEBOUNCE:
                        settings.debounce_ticks   = cfg_data[mcbd_pkg::DebounceW-1:0];
                    mcbd_pkg::CFG_LONG:
                        settings.long_press_ticks = cfg_data[mcbd_pkg::LongW-1:0];
                    mcbd_pkg::CFG_SETTLE:
                        settings.settle_ticks     = cfg_data[mcbd_pkg::SettleW-1:0];
                    mcbd_pkg::CFG_MAXCLK:
                        settings.max_clicks       = cfg_data[mcbd_pkg::ClicksW-1:0];
                    default: ;
                endcase
                n_write++;
            end
        end
        n_queue = expected_events.size();
    end

endmodule

// ===== verif/multi_click_button_detector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_click_button_detector_tb
// Drives button sample ticks and register writes into the detector: a short
// directed run of clicks, too-many runs and long presses, then click runs,
// long presses and chatter with random timing under several register
// settings and handshake idling mixes. A checker module does the prediction.
// ----------------------------------------------------------------------------
module multi_click_button_detector_tb;

    localparam int CLK_PERIOD     = 8;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid;
    logic                          in_stall;
    logic                          level_low;
    logic                          out_valid;
    logic                          out_stall;
    logic [mcbd_pkg::KindW-1:0]    event_kind;
    logic [mcbd_pkg::CountW-1:0]   click_count;
    logic                          is_down;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [mcbd_pkg::CfgIdxW-1:0]  cfg_index;
    logic [mcbd_pkg::CfgDataW-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int ticks_seen;
    int clicks_seen;
    int many_seen;
    int longs_seen;
    int writes_seen;

    int send_gap_pct = 0;
    int stall_pct    = 0;
    int hold_req     = 0;
    int hold_ack     = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int sent         = 0;
    int cur_db       = mcbd_pkg::DEBOUNCE_RST;
    int cur_long     = mcbd_pkg::LONG_RST;
    int cur_settle   = mcbd_pkg::SETTLE_RST;

    multi_click_button_detector dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .level_low   (level_low),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .click_count (click_count),
        .is_down     (is_down),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    button_event_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .level_low   (level_low),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .click_count (click_count),
        .is_down     (is_down),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .ticks_seen  (ticks_seen),
        .clicks_seen (clicks_seen),
        .many_seen   (many_seen),
        .longs_seen  (longs_seen),
        .writes_seen (writes_seen)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // event receiver: random stall, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_ack != hold_req)
        begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99, 0) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("multi_click_button_detector_tb: FAIL");
            $finish;
        end
    end

    task automatic send_tick(input logic lvl);
        @(negedge clk);
        while (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        level_low <= lvl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic hold_level(input logic lvl, input int n);
        repeat (n) send_tick(lvl);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [mcbd_pkg::CfgIdxW-1:0] idx,
                             input logic [mcbd_pkg::CfgDataW-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // upper data bits of the narrow registers carry junk
    task automatic configure(input int db, input int lp, input int st, input int mc);
        drain();
        write_reg(mcbd_pkg::CFG_DEBOUNCE, {8'($urandom), 8'(db)});
        write_reg(mcbd_pkg::CFG_LONG, 16'(lp));
        write_reg(mcbd_pkg::CFG_SETTLE, 16'(st));
        write_reg(mcbd_pkg::CFG_MAXCLK, {12'($urandom), 4'(mc)});
        @(negedge clk);
        cfg_valid  <= 1'b0;
        cur_db     = db;
        cur_long   = lp;
        cur_settle = st;
    endtask

    task automatic set_idling(input int gap, input int stall);
        send_gap_pct = gap;
        stall_pct    = stall;
    endtask

    task automatic click_run(input int presses);
        repeat (presses)
        begin
            hold_level(1'b1, $urandom_range(cur_db + cur_long, cur_db + 1));
            hold_level(1'b0, $urandom_range(cur_db + cur_settle, cur_db + 1));
        end
        hold_level(1'b0, cur_db + cur_settle + $urandom_range(4, 2));
    endtask

    task automatic long_press();
        hold_level(1'b1, cur_db + cur_long + $urandom_range(6, 2));
        hold_level(1'b0, cur_db + cur_settle + 2);
    endtask

    task automatic chatter(input int n);
        repeat (n) send_tick(1'($urandom_range(1, 0)));
    endtask

    task automatic random_burst(input int n);
        int start;
        int pick;
        start = sent;
        while (sent - start < n)
        begin
            pick = $urandom_range(9, 0);
            if (pick < 6)
                click_run($urandom_range(4, 1));
            else if (pick == 6)
                click_run($urandom_range(17, 5));
            else if (pick < 9)
                long_press();
            else
                chatter($urandom_range(8, 1));
        end
    endtask

    initial
    begin
        in_valid  = 1'b0;
        level_low = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = mcbd_pkg::CFG_DEBOUNCE;
        cfg_data  = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: bounce inside the debounce window, then a short press
        chatter(20);
        hold_level(1'b1, 30);
        hold_level(1'b0, 10);

        // directed: no debounce, short timers
        configure(0, 2, 1, 1);
        hold_level(1'b1, 1);
        hold_level(1'b0, 3);
        hold_level(1'b0, 1);
        hold_level(1'b1, 1);
        hold_level(1'b0, 1);
        hold_level(1'b1, 1);
        hold_level(1'b0, 3);
        hold_level(1'b1, 5);
        hold_level(1'b0, 1);
        configure(0, 2, 1, 0);
        hold_level(1'b1, 1);
        hold_level(1'b0, 3);

        for (int p = 0; p < 8; p++)
        begin
            case (p / 2)
                0:       set_idling(0, 0);
                1:       set_idling(87, 0);
                2:       set_idling(0, 87);
                default: set_idling(7, 7);
            endcase
            configure($urandom_range(2, 0), $urandom_range(10, 3),
                      $urandom_range(8, 1), $urandom_range(15, 0));
            if (p == 0)
            begin
                @(posedge clk);
                hold_req++;
            end
            if (p == 1)
                click_run(17);
            random_burst(25);
            if (p == 2)
                drain();
            random_burst(25);
        end

        // full-scale debounce with zero timers, then full-scale timers
        set_idling(0, 0);
        configure(255, 0, 0, 15);
        hold_level(1'b1, 260);
        hold_level(1'b0, 40);
        set_idling(7, 7);
        configure(0, 65535, 65535, 15);
        chatter(30);
        hold_level(1'b1, 10);
        hold_level(1'b0, 10);

        drain();
        repeat (8) @(negedge clk);
        $display("covered %0d ticks: %0d click runs, %0d too-many runs, %0d long presses",
                 ticks_seen, clicks_seen, many_seen, longs_seen);
        $display("%0d register writes, debounce 0..255, timers 0..65535, four idling mixes",
                 writes_seen);
        if (mismatches == 0)
            $display("multi_click_button_detector_tb: PASS");
        else
            $display("multi_click_button_detector_tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/mcbd_pkg.sv
src/mcbd_cfg_regs.sv
src/mcbd_core.sv
src/mcbd_out_skid.sv
src/multi_click_button_detector.sv
verif/button_event_checker.sv
verif/multi_click_button_detector_tb.sv
